// ----- src/sttf_pkg.sv -----
package sttf_pkg;

    // Stored task: type bit, packed identifier, signed order key
    typedef struct packed {
        logic               ttype;
        logic [31:0]        name;
        logic signed [31:0] key;
    } t_task;

    // Per-cycle commands from the controller to every cell
    typedef struct packed {
        logic ins;   // sorted insert of the incoming task
        logic pop;   // shift the whole row one place toward the head
    } t_cell_ctl;

    // Controller states
    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    // Configuration register indexes
    localparam logic CFG_KEY_THRESHOLD = 1'b0;
    localparam logic CFG_WANTED_TYPE   = 1'b1;

endpackage

// ----- src/sorted_task_threshold_filter_top.sv -----
// Sorted task filter. Tasks stream in on the slave side, one transaction per cycle,
// and drop into place in a row of MAX_TASKS cells that keeps them ordered by signed
// key (equal keys stay in arrival order) as they arrive; each cell compares the
// incoming key with its own in the same cycle. Tasks past MAX_TASKS are discarded
// and reported through the dropped flag. The transaction with tlast ends the batch:
// o_s_axis_tready then drops and the row drains from its head one cell per cycle,
// stalling while a result waits on the master side, and emits each task of the wanted
// type whose key is below the threshold, until the first key at or above the threshold
// or the row runs empty. The last result carries tlast; a batch with no match yields
// one result with found clear and zero data. Configuration must be written only while
// no batch is in flight; the block itself does not enforce this.
module sorted_task_threshold_filter_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // task input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] task_name, [63:32] task_key
    input  logic        i_s_axis_tuser,   // [0] task_type
    input  logic        i_s_axis_tlast,   // is_last_task
    // result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] out_name, [63:32] out_key
    output logic [1:0]  o_m_axis_tuser,   // [0] found, [1] dropped
    output logic        o_m_axis_tlast    // run_end
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

    // Configuration registers
    logic signed [31:0] r_thr;
    logic               r_want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_want <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sttf_pkg::CFG_KEY_THRESHOLD: r_thr  <= i_cfg_data;
                sttf_pkg::CFG_WANTED_TYPE:   r_want <= i_cfg_data[0];
                default:                     r_thr  <= r_thr;
            endcase
        end
    end

    // Control state
    sttf_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_pend_vld, n_pend_vld;
    sttf_pkg::t_task  r_pend, n_pend;
    logic             r_out_vld, n_out_vld;
    logic             r_out_found, n_out_found;
    logic             r_out_last, n_out_last;
    logic             r_out_drop, n_out_drop;
    logic [31:0]      r_out_name, n_out_name;
    logic [31:0]      r_out_key, n_out_key;

    sttf_pkg::t_task   w_new;
    sttf_pkg::t_task   w_cell [MAX_TASKS];
    logic              w_lt   [MAX_TASKS];
    sttf_pkg::t_cell_ctl w_ctl;

    logic w_in_acc, w_full, w_can_push, w_head_vld, w_below, w_match, w_term;
    logic w_drain_step;

    assign w_new.ttype = i_s_axis_tuser;
    assign w_new.name  = i_s_axis_tdata[31:0];
    assign w_new.key   = i_s_axis_tdata[63:32];

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full     = (r_count == FULL);
    assign w_can_push = !r_out_vld || i_m_axis_tready;
    assign w_head_vld = (r_count != '0);
    assign w_below    = (w_cell[0].key < r_thr);
    assign w_match    = w_head_vld && w_below && (w_cell[0].ttype == r_want);
    assign w_term     = !w_head_vld || !w_below;
    assign w_drain_step = (r_state == sttf_pkg::ST_DRAIN) && w_can_push;

    // Row of sorting cells
    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        sttf_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_empty   (CW'(g) >= r_count),
            .i_new     (w_new),
            .i_prev    ((g == 0) ? w_new : w_cell[(g == 0) ? 0 : g - 1]),
            .i_prev_lt ((g == 0) ? 1'b0 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_next    ((g == MAX_TASKS - 1) ? w_cell[g] :
                        w_cell[(g == MAX_TASKS - 1) ? g : g + 1]),
            .o_task    (w_cell[g]),
            .o_lt      (w_lt[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sttf_pkg::ST_LOAD: begin
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = sttf_pkg::ST_DRAIN;
                end
            end
            sttf_pkg::ST_DRAIN: begin
                if (w_can_push && w_term) begin
                    n_state = sttf_pkg::ST_LOAD;
                end
            end
            default: n_state = sttf_pkg::ST_LOAD;
        endcase
    end

    // Outputs of the controller: cell commands, count, pending and output registers
    always_comb begin
        o_s_axis_tready = (r_state == sttf_pkg::ST_LOAD);
        w_ctl.ins   = w_in_acc && !w_full;
        w_ctl.pop   = w_drain_step && !w_term;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pend_vld  = r_pend_vld;
        n_pend      = r_pend;
        n_out_vld   = r_out_vld && !i_m_axis_tready;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        n_out_name  = r_out_name;
        n_out_key   = r_out_key;

        if (w_in_acc) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end

        if (w_drain_step) begin
            if (w_term) begin
                // batch end: flush the held match or report no match
                n_out_vld   = 1'b1;
                n_out_found = r_pend_vld;
                n_out_last  = 1'b1;
                n_out_drop  = r_ovf;
                n_out_name  = r_pend_vld ? r_pend.name : '0;
                n_out_key   = r_pend_vld ? r_pend.key  : '0;
                n_pend_vld  = 1'b0;
                n_count     = '0;
                n_ovf       = 1'b0;
            end else begin
                n_count = r_count - CW'(1);
                if (w_match) begin
                    // hold the new match; the older one is known not to be last
                    n_pend     = w_cell[0];
                    n_pend_vld = 1'b1;
                    if (r_pend_vld) begin
                        n_out_vld   = 1'b1;
                        n_out_found = 1'b1;
                        n_out_last  = 1'b0;
                        n_out_drop  = r_ovf;
                        n_out_name  = r_pend.name;
                        n_out_key   = r_pend.key;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sttf_pkg::ST_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
        r_out_name  <= n_out_name;
        r_out_key   <= n_out_key;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_key, r_out_name};
    assign o_m_axis_tuser  = {r_out_drop, r_out_found};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // Stored task count never exceeds the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("task count beyond capacity");

    // A held match exists only while the row drains
    a_pend_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == sttf_pkg::ST_DRAIN))
        else $error("pending match outside drain");

    // A no-match result always closes its batch
    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_found) |-> r_out_last)
        else $error("no-match result without run end");

    // Head two cells stay in key order while two or more tasks are stored
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_cell[0].key <= w_cell[1].key))
        else $error("row out of key order");
`endif

endmodule

// ----- src/sttf_cell.sv -----
module sttf_cell (
    input  logic              i_clk,
    input  sttf_pkg::t_cell_ctl i_ctl,
    input  logic              i_empty,     // this cell holds no task of the batch
    input  sttf_pkg::t_task   i_new,       // incoming task, broadcast to all cells
    input  sttf_pkg::t_task   i_prev,      // content of the neighbor nearer the head
    input  logic              i_prev_lt,   // neighbor nearer the head moves down
    input  sttf_pkg::t_task   i_next,      // content of the neighbor farther from the head
    output sttf_pkg::t_task   o_task,
    output logic              o_lt
);

    sttf_pkg::t_task r_task;
    sttf_pkg::t_task n_task;

    // New task goes before this one only on a strictly smaller key (keeps load order)
    assign o_lt = i_empty || (i_new.key < r_task.key);

    // Insert: take the new task at the boundary, the neighbor's content below it; pop: take the next neighbor's content
    always_comb begin
        n_task = r_task;
        if (i_ctl.ins && o_lt) begin
            n_task = i_prev_lt ? i_prev : i_new;
        end else if (i_ctl.pop) begin
            n_task = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
    end

    assign o_task = r_task;

endmodule

// ----- tb/tb_sorted_task_threshold_filter_top.sv -----
`timescale 1ns / 1ps

module tb_sorted_task_threshold_filter_top;

    localparam int TASK_SLOTS  = 16;
    localparam int RAND_TASKS  = 390;
    localparam int DRAIN_GAP   = 4;
    localparam int END_GAP     = 20;
    localparam int STALL_LIMIT = 2000;

    // One emitted result as the master side should carry it
    typedef struct packed {
        logic               found;
        logic [31:0]        name;
        logic signed [31:0] key;
        logic               run_end;
        logic               dropped;
    } t_result;

    typedef enum logic {
        ROW_TASK = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    // Directed stimulus row; a ROW_CFG row carries the threshold in key and the
    // wanted type in ttype
    typedef struct packed {
        t_row_kind          kind;
        logic               ttype;
        logic [31:0]        name;
        logic signed [31:0] key;
        logic               last;
        logic               typed;
        t_result            want;
    } t_row;

    typedef enum logic [1:0] {
        IDLE_SENDER_LIGHT,
        IDLE_SENDER_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    localparam t_result NO_MATCH_CLEAN = '{1'b0, 32'h0, 32'sh0, 1'b1, 1'b0};

    localparam int N_ROWS = 29;
    localparam t_row DIRECTED [N_ROWS] = '{
        // reset settings: threshold 0, type 0
        '{ROW_TASK, 1'b0, 32'h5253_5430, -32'sd5, 1'b1, 1'b1,
          '{1'b1, 32'h5253_5430, -32'sd5, 1'b1, 1'b0}},
        '{ROW_TASK, 1'b0, 32'h0000_0000, 32'sd0, 1'b1, 1'b1, NO_MATCH_CLEAN},
        // key extremes against the largest threshold
        '{ROW_CFG,  1'b1, 32'h0, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h1234_5678, 32'sd3, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'h0000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0, '0},
        // equal keys keep arrival order
        '{ROW_TASK, 1'b1, 32'h4551_5F41, 32'sd7, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'h4551_5F42, -32'sd1, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'h4551_5F43, 32'sd7, 1'b1, 1'b0, '0},
        // capacity overflow; the dropped task carries the end flag
        '{ROW_CFG,  1'b0, 32'h0, 32'sd100, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0000, 32'sd9, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0001, -32'sd3, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'h4F56_0002, 32'sd9, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0003, 32'sd0, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0004, 32'sd5, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'h4F56_0005, -32'sd3, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0006, 32'sd12, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0007, -32'sd20, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0008, 32'sd7, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0009, 32'sd1, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_000A, 32'sd2, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'h4F56_000B, 32'sd3, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_000C, 32'sd4, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_000D, 32'sd5, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_000E, 32'sd6, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_000F, 32'sd7, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b0, 32'h4F56_0010, 32'sd8, 1'b1, 1'b0, '0},
        // smallest threshold: nothing can pass
        '{ROW_CFG,  1'b1, 32'h0, 32'sh8000_0000, 1'b0, 1'b0, '0},
        '{ROW_TASK, 1'b1, 32'hA5A5_A5A5, 32'sh8000_0000, 1'b1, 1'b1, NO_MATCH_CLEAN}
    };

    // DUT-facing signals, known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_addr      = sttf_pkg::CFG_KEY_THRESHOLD;
    logic [31:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata  = '0;   // [31:0] task_name, [63:32] task_key
    logic        i_s_axis_tuser  = 1'b0; // [0] task_type
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;         // [31:0] out_name, [63:32] out_key
    logic [1:0]  o_m_axis_tuser;         // [0] found, [1] dropped
    logic        o_m_axis_tlast;

    // Predictor state and bookkeeping
    sttf_pkg::t_task    held_tasks[$];
    logic               held_overflow    = 1'b0;
    logic signed [31:0] filter_threshold = '0;
    logic               filter_type      = 1'b0;
    t_result            fresh_results[$];
    t_result            due_results[$];

    int gap_pct         = 6;
    int stall_pct       = 75;
    int mismatch_count  = 0;
    int tasks_sent      = 0;
    int batches_done    = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int idle_cycles     = 0;

    sorted_task_threshold_filter_top #(
        .MAX_TASKS(TASK_SLOTS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Store one task; on the end flag, stable-sort by signed key and emit the
    // wanted-type tasks below the threshold into fresh_results
    function automatic void absorb_task(input sttf_pkg::t_task tk, input logic last);
        sttf_pkg::t_task ordered[$];
        int              pos;
        t_result         res;
        fresh_results.delete();
        if (held_tasks.size() < TASK_SLOTS) begin
            held_tasks.push_back(tk);
        end else begin
            held_overflow = 1'b1;
        end
        if (!last) return;
        foreach (held_tasks[i]) begin
            pos = ordered.size();
            while (pos > 0 && $signed(ordered[pos-1].key) > $signed(held_tasks[i].key))
                pos--;
            ordered.insert(pos, held_tasks[i]);
        end
        foreach (ordered[i]) begin
            if ($signed(ordered[i].key) >= $signed(filter_threshold)) break;
            if (ordered[i].ttype == filter_type) begin
                res = '{1'b1, ordered[i].name, ordered[i].key, 1'b0, held_overflow};
                fresh_results.push_back(res);
            end
        end
        if (fresh_results.size() == 0) begin
            res = '{1'b0, 32'h0, 32'sh0, 1'b0, held_overflow};
            fresh_results.push_back(res);
        end
        fresh_results[fresh_results.size()-1].run_end = 1'b1;
        held_tasks.delete();
        held_overflow = 1'b0;
        batches_done++;
    endfunction

    // Offer one task until accepted, log its expected results, maybe go idle
    task automatic push_task(input sttf_pkg::t_task tk, input logic last, input logic typed,
                             input t_result want);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {tk.key, tk.name};
        i_s_axis_tuser  <= tk.ttype;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tasks_sent++;
        absorb_task(tk, last);
        if (typed) begin
            due_results.push_back(want);
        end else begin
            foreach (fresh_results[i]) due_results.push_back(fresh_results[i]);
        end
        // each idle cycle drawn separately, so gap_pct is the idle share
        while ($urandom_range(1, 100) <= gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold the sender until every pending result is out, then let the block settle
    task automatic wait_results_done();
        i_s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // Write both filter registers with the block idle
    task automatic load_filter(input logic signed [31:0] thr, input logic wt);
        wait_results_done();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sttf_pkg::CFG_KEY_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_addr <= sttf_pkg::CFG_WANTED_TYPE;
        i_cfg_data <= {31'b0, wt};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        filter_threshold = thr;
        filter_type      = wt;
        cfg_writes += 2;
    endtask

    // Key mix: full range, clustered (many ties), extremes, moderate
    function automatic logic signed [31:0] pick_key();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom;
            1: begin
                v = $urandom_range(0, 16);
                v = v - 32'd8;
            end
            2:       v = 32'h8000_0000;
            3:       v = 32'h7FFF_FFFF;
            default: begin
                v = $urandom_range(0, 2000);
                v = v - 32'd1000;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pick_threshold();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = $urandom;
            3:       v = 32'h0;
            default: begin
                v = $urandom_range(0, 1000);
                v = v - 32'd300;
            end
        endcase
        return v;
    endfunction

    // Result checker and receiver back-pressure
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with none pending", o_m_axis_tdata[31:0], 32'h0);
            end else begin
                exp_res = due_results.pop_front();
                results_checked++;
                if (o_m_axis_tuser[0] !== exp_res.found)
                    report_mismatch("found", {31'b0, o_m_axis_tuser[0]}, {31'b0, exp_res.found});
                if (o_m_axis_tdata[31:0] !== exp_res.name)
                    report_mismatch("out_name", o_m_axis_tdata[31:0], exp_res.name);
                if (o_m_axis_tdata[63:32] !== exp_res.key)
                    report_mismatch("out_key", o_m_axis_tdata[63:32], exp_res.key);
                if (o_m_axis_tlast !== exp_res.run_end)
                    report_mismatch("run_end", {31'b0, o_m_axis_tlast}, {31'b0, exp_res.run_end});
                if (o_m_axis_tuser[1] !== exp_res.dropped)
                    report_mismatch("dropped", {31'b0, o_m_axis_tuser[1]},
                                    {31'b0, exp_res.dropped});
            end
        end
        i_m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
    end

    // Watchdog: cycles without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        sttf_pkg::t_task tk;
        t_idle_mode      mode;
        t_idle_mode      next_mode;
        int              rand_sent;
        int              batch_len;

        mode      = IDLE_SENDER_LIGHT;
        rand_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                load_filter(DIRECTED[r].key, DIRECTED[r].ttype);
            end else begin
                tk = '{DIRECTED[r].ttype, DIRECTED[r].name, DIRECTED[r].key};
                push_task(tk, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // random batches, occasional overflow, config changes between batches
        while (rand_sent < RAND_TASKS) begin
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(TASK_SLOTS + 1, 20)
                                                    : $urandom_range(1, TASK_SLOTS);
            for (int k = 0; k < batch_len; k++) begin
                tk.ttype = 1'($urandom_range(0, 1));
                tk.name  = $urandom;
                tk.key   = pick_key();
                push_task(tk, k == batch_len - 1, 1'b0, '0);
            end
            rand_sent += batch_len;

            if (rand_sent < RAND_TASKS / 3)          next_mode = IDLE_SENDER_LIGHT;
            else if (rand_sent < 2 * RAND_TASKS / 3) next_mode = IDLE_SENDER_HEAVY;
            else                                     next_mode = IDLE_NONE;
            if (next_mode != mode) begin
                wait_results_done();
                mode = next_mode;
                case (mode)
                    IDLE_SENDER_HEAVY: begin
                        gap_pct   = 75;
                        stall_pct = 6;
                    end
                    IDLE_NONE: begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                    default: begin
                        gap_pct   = 6;
                        stall_pct = 75;
                    end
                endcase
            end

            if ($urandom_range(0, 3) == 0)
                load_filter(pick_threshold(), 1'($urandom_range(0, 1)));
        end

        i_s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (END_GAP) @(posedge i_clk);

        $display("Sent %0d tasks in %0d batches, checked %0d results.",
                 tasks_sent, batches_done, results_checked);
        $display("Filter registers written %0d times; %0d mismatches.",
                 cfg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
